// File: design/ccsf_pkg.sv
package ccsf_pkg;

   localparam logic [14:0] VOLT_MAX = 15'd20000;
   localparam logic [13:0] CURR_MAX = 14'd10000;
   localparam logic [15:0] TIMEOUT_RESET = 16'd100;

   // register index taken from paddr[2]
   localparam logic REG_TIMEOUT = 1'b0;
   localparam logic REG_CONNECTOR = 1'b1;

   typedef enum logic [2:0] {
      ST_DISC  = 3'd0,
      ST_KEY   = 3'd1,
      ST_ALLOC = 3'd2,
      ST_RUN   = 3'd3,
      ST_DONE  = 3'd4
   } state_type;

   typedef enum logic [2:0] {
      MODE_CONNECT    = 3'd0,
      MODE_DISCONNECT = 3'd1,
      MODE_NEW_PHASE  = 3'd2,
      MODE_ALLOC_RSP  = 3'd3,
      MODE_KEY        = 3'd4,
      MODE_TICK       = 3'd5,
      MODE_REQUEST    = 3'd6,
      MODE_NOP        = 3'd7
   } mode_type;

   typedef enum logic [2:0] {
      PH_OFF          = 3'd0,
      PH_EXPORT_CHECK = 3'd1,
      PH_OFF_CHECK    = 3'd2,
      PH_PRECHARGE    = 3'd3,
      PH_CHARGING     = 3'd4
   } phase_type;

   typedef enum logic [2:0] {
      WS_STANDBY  = 3'd0,
      WS_PLUGGED  = 3'd1,
      WS_STARTING = 3'd2,
      WS_CHARGING = 3'd3,
      WS_COMPLETE = 3'd4
   } working_type;

   typedef enum logic [1:0] {
      EV_NONE     = 2'd0,
      EV_START    = 2'd1,
      EV_STOP     = 2'd2
   } event_type;

   typedef enum logic [2:0] {
      FR_NONE      = 3'd0,
      FR_STOP      = 3'd1,
      FR_ALLOC     = 3'd2,
      FR_INS_OUT   = 3'd3,
      FR_INS_STOP  = 3'd4,
      FR_PRECHARGE = 3'd5,
      FR_CHARGING  = 3'd6
   } frame_type;

   typedef struct packed {
      logic [2:0]  mode;
      logic [2:0]  phase_in;
      logic        alloc_success;
      logic [14:0] req_voltage_in;
      logic [13:0] req_current_in;
   } req_word_type;

   typedef struct packed {
      logic [2:0]  session_state;
      logic [2:0]  phase_out;
      logic [2:0]  charge_status;
      logic        link_status;
      logic [1:0]  charging_event;
      logic [2:0]  frame_kind;
      logic [7:0]  frame_connector;
      logic [14:0] frame_voltage;
      logic [13:0] frame_current;
      logic        alloc_failed;
      logic        status_changed;
   } rsp_word_type;

endpackage

// File: design/charge_connector_session_fsm.sv
// channel   | direction | handshake              | word
// req       | in        | req_valid / req_stall  | ccsf_pkg::req_word_type
// rsp       | out       | rsp_valid / rsp_stall  | ccsf_pkg::rsp_word_type
// csr       | in/out    | psel/penable, pready=1 | alloc_timeout_ticks, connector_id
//
// one word per cycle sustained while rsp is not stalled; an accepted word passes through the
// input register, then the session update into the result register, before it is offered on rsp
// synchronous active-high reset returns the session to disconnected, timeout to 100
// a stalled result holds in the output register while one more word waits in the
// input register; req_stall rises only when both are occupied and rsp is stalled
module charge_connector_session_fsm (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  ccsf_pkg::req_word_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output ccsf_pkg::rsp_word_type rsp_data,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [2:0]             paddr,
   input  logic [31:0]            pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);

   logic [15:0] timeout_cfg_ff;
   logic [7:0]  connector_ff;

   logic                   in_valid_ff;
   ccsf_pkg::req_word_type in_word_ff;
   logic                   out_valid_ff;
   ccsf_pkg::rsp_word_type out_word_ff, out_word_in;

   ccsf_pkg::state_type state_ff, state_in;
   logic [2:0]  phase_ff, phase_in;
   logic [14:0] volt_ff, volt_in;
   logic [13:0] curr_ff, curr_in;
   logic [15:0] count_ff, count_in;
   logic        armed_ff, armed_in;
   logic        failed_ff, failed_in;

   logic out_free, fire;

   // ---------------- configuration port
   assign pready = 1'b1;
   assign prdata = (paddr[2] == ccsf_pkg::REG_CONNECTOR) ? {24'd0, connector_ff}
                                                         : {16'd0, timeout_cfg_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_cfg_ff <= ccsf_pkg::TIMEOUT_RESET;
         connector_ff   <= 8'd0;
      end else if (psel && penable && pwrite && pready) begin
         if (paddr[2] == ccsf_pkg::REG_CONNECTOR) begin
            connector_ff <= pwdata[7:0];
         end else begin
            timeout_cfg_ff <= pwdata[15:0];
         end
      end
   end

   // ---------------- handshake
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         in_valid_ff <= 1'b1;
      end else if (fire) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_word_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (fire) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_word_ff <= out_word_in;
      end
   end

   // ---------------- session state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ccsf_pkg::ST_DISC;
         phase_ff  <= ccsf_pkg::PH_OFF;
         volt_ff   <= 15'd0;
         curr_ff   <= 14'd0;
         count_ff  <= 16'd0;
         armed_ff  <= 1'b0;
         failed_ff <= 1'b0;
      end else if (fire) begin
         state_ff  <= state_in;
         phase_ff  <= phase_in;
         volt_ff   <= volt_in;
         curr_ff   <= curr_in;
         count_ff  <= count_in;
         armed_ff  <= armed_in;
         failed_ff <= failed_in;
      end
   end

   always_comb begin
      logic                want_state, want_phase, force_frame;
      logic                st_chg, ph_chg, carries_req;
      ccsf_pkg::state_type nst;
      logic [2:0]          nph, kind, working;
      logic [15:0]         count_inc;
      logic [1:0]          ev;

      want_state  = 1'b0;
      want_phase  = 1'b0;
      force_frame = 1'b0;
      nst         = state_ff;
      nph         = phase_ff;
      volt_in     = volt_ff;
      curr_in     = curr_ff;
      count_in    = count_ff;
      armed_in    = armed_ff;
      failed_in   = failed_ff;
      count_inc   = count_ff + 16'd1;

      case (ccsf_pkg::mode_type'(in_word_ff.mode))
         ccsf_pkg::MODE_CONNECT: begin
            if (state_ff == ccsf_pkg::ST_DISC) begin
               want_state = 1'b1;
               nst = ccsf_pkg::ST_KEY;
            end
         end
         ccsf_pkg::MODE_DISCONNECT: begin
            if (state_ff != ccsf_pkg::ST_DISC) begin
               want_state = 1'b1;
               nst = ccsf_pkg::ST_DISC;
            end
         end
         ccsf_pkg::MODE_NEW_PHASE: begin
            if (in_word_ff.phase_in <= ccsf_pkg::PH_CHARGING) begin
               want_phase = 1'b1;
               nph = in_word_ff.phase_in;
               if (state_ff == ccsf_pkg::ST_RUN && in_word_ff.phase_in == ccsf_pkg::PH_OFF)
               begin
                  want_state = 1'b1;
                  nst = ccsf_pkg::ST_DONE;
               end else if (state_ff == ccsf_pkg::ST_DONE &&
                            (in_word_ff.phase_in == ccsf_pkg::PH_EXPORT_CHECK ||
                             in_word_ff.phase_in == ccsf_pkg::PH_PRECHARGE ||
                             in_word_ff.phase_in == ccsf_pkg::PH_CHARGING)) begin
                  want_state = 1'b1;
                  nst = ccsf_pkg::ST_KEY;
               end
            end
         end
         ccsf_pkg::MODE_ALLOC_RSP: begin
            armed_in = 1'b0;
            if (state_ff == ccsf_pkg::ST_ALLOC) begin
               failed_in  = !in_word_ff.alloc_success;
               want_state = 1'b1;
               nst = ccsf_pkg::ST_RUN;
            end
         end
         ccsf_pkg::MODE_KEY: begin
            if (state_ff == ccsf_pkg::ST_KEY) begin
               want_state = 1'b1;
               nst = ccsf_pkg::ST_ALLOC;
            end
         end
         ccsf_pkg::MODE_TICK: begin
            if (armed_ff) begin
               count_in = count_inc;
               if (count_inc >= timeout_cfg_ff) begin
                  armed_in = 1'b0;
                  if (state_ff == ccsf_pkg::ST_ALLOC) begin
                     failed_in  = 1'b1;
                     want_state = 1'b1;
                     nst = ccsf_pkg::ST_RUN;
                  end
               end
            end
         end
         ccsf_pkg::MODE_REQUEST: begin
            volt_in = (in_word_ff.req_voltage_in > ccsf_pkg::VOLT_MAX) ?
                      ccsf_pkg::VOLT_MAX : in_word_ff.req_voltage_in;
            curr_in = (in_word_ff.req_current_in > ccsf_pkg::CURR_MAX) ?
                      ccsf_pkg::CURR_MAX : in_word_ff.req_current_in;
            force_frame = (state_ff == ccsf_pkg::ST_RUN);
         end
         default: begin
         end
      endcase

      st_chg   = want_state && (nst != state_ff);
      ph_chg   = want_phase && (nph != phase_ff);
      state_in = st_chg ? nst : state_ff;
      phase_in = ph_chg ? nph : phase_ff;

      ev = ccsf_pkg::EV_NONE;
      if (st_chg) begin
         ev = (state_in == ccsf_pkg::ST_RUN) ? ccsf_pkg::EV_START : ccsf_pkg::EV_STOP;
         if (state_in == ccsf_pkg::ST_ALLOC) begin
            count_in = 16'd0;
            armed_in = 1'b1;
         end
         if (state_in != ccsf_pkg::ST_RUN) begin
            failed_in = 1'b0;
         end
      end

      kind = ccsf_pkg::FR_NONE;
      if (st_chg || ph_chg || force_frame) begin
         case (state_in)
            ccsf_pkg::ST_ALLOC: kind = ccsf_pkg::FR_ALLOC;
            ccsf_pkg::ST_RUN: begin
               case (phase_in)
                  ccsf_pkg::PH_EXPORT_CHECK: kind = ccsf_pkg::FR_INS_OUT;
                  ccsf_pkg::PH_OFF_CHECK:    kind = ccsf_pkg::FR_INS_STOP;
                  ccsf_pkg::PH_PRECHARGE:    kind = ccsf_pkg::FR_PRECHARGE;
                  ccsf_pkg::PH_CHARGING:     kind = ccsf_pkg::FR_CHARGING;
                  default:                   kind = ccsf_pkg::FR_ALLOC;
               endcase
            end
            default: kind = ccsf_pkg::FR_STOP;
         endcase
      end
      carries_req = (kind == ccsf_pkg::FR_INS_OUT) || (kind == ccsf_pkg::FR_PRECHARGE) ||
                    (kind == ccsf_pkg::FR_CHARGING);

      case (state_in)
         ccsf_pkg::ST_DISC:  working = ccsf_pkg::WS_STANDBY;
         ccsf_pkg::ST_KEY:   working = ccsf_pkg::WS_PLUGGED;
         ccsf_pkg::ST_ALLOC: working = ccsf_pkg::WS_STARTING;
         ccsf_pkg::ST_RUN:   working = (phase_in == ccsf_pkg::PH_CHARGING) ?
                                       ccsf_pkg::WS_CHARGING : ccsf_pkg::WS_STARTING;
         default:            working = ccsf_pkg::WS_COMPLETE;
      endcase

      out_word_in.session_state   = state_in;
      out_word_in.phase_out       = phase_in;
      out_word_in.charge_status   = working;
      out_word_in.link_status     = (state_in != ccsf_pkg::ST_DISC);
      out_word_in.charging_event  = ev;
      out_word_in.frame_kind      = kind;
      out_word_in.frame_connector = (kind != ccsf_pkg::FR_NONE) ? connector_ff : 8'd0;
      out_word_in.frame_voltage   = carries_req ? volt_in : 15'd0;
      out_word_in.frame_current   = carries_req ? curr_in : 14'd0;
      out_word_in.alloc_failed    = failed_in;
      out_word_in.status_changed  = st_chg || ph_chg;
   end

endmodule

// File: design/ccsf_checker.sv
module ccsf_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input ccsf_pkg::rsp_word_type rsp_data
);

   // a stalled result stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled rsp word changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.link_status ==
                    (rsp_data.session_state != ccsf_pkg::ST_DISC))
      else $error("link status disagrees with session state");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.charging_event == ccsf_pkg::EV_START |->
         rsp_data.session_state == ccsf_pkg::ST_RUN && rsp_data.status_changed)
      else $error("start event outside entry to running");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.status_changed |-> rsp_data.charging_event == ccsf_pkg::EV_NONE)
      else $error("charging event without a change");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frame_kind == ccsf_pkg::FR_NONE |->
         rsp_data.frame_connector == 8'd0 && rsp_data.frame_voltage == 15'd0 &&
         rsp_data.frame_current == 14'd0)
      else $error("frame fields set with no frame");

endmodule

bind charge_connector_session_fsm ccsf_checker u_ccsf_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// File: tb/sv/session_checker.sv
module session_checker
   import ccsf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_stall,
   input  req_word_type req_data,
   input  logic         rsp_valid,
   input  logic         rsp_stall,
   input  rsp_word_type rsp_data,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic         pready,
   input  logic [2:0]   paddr,
   input  logic [31:0]  pwdata,
   output int           fail_count,
   output int           pending_count,
   output int           checked_count
);
   timeunit 1ns;
   timeprecision 1ps;

   // session copy kept by the checker
   state_type   sess_state;
   phase_type   sess_phase;
   logic [14:0] held_volt;
   logic [13:0] held_curr;
   logic [15:0] tick_count;
   logic        tick_armed;
   logic        fail_flag;
   logic [15:0] cfg_timeout;
   logic [7:0]  cfg_connector;

   rsp_word_type expected_status_q[$];
   rsp_word_type oldest_status;
   int           fails;
   int           checked;

   function automatic rsp_word_type predict_session_event(input req_word_type w);
      state_type    nst;
      phase_type    nph;
      frame_type    kind;
      logic         want_st;
      logic         want_ph;
      logic         force_frame;
      logic         st_chg;
      logic         ph_chg;
      rsp_word_type r;
      nst = sess_state;
      nph = sess_phase;
      want_st = 1'b0;
      want_ph = 1'b0;
      force_frame = 1'b0;
      case (w.mode)
         MODE_CONNECT: begin
            if (sess_state == ST_DISC) begin
               want_st = 1'b1;
               nst = ST_KEY;
            end
         end
         MODE_DISCONNECT: begin
            if (sess_state != ST_DISC) begin
               want_st = 1'b1;
               nst = ST_DISC;
            end
         end
         MODE_NEW_PHASE: begin
            if (w.phase_in <= PH_CHARGING) begin
               want_ph = 1'b1;
               nph = phase_type'(w.phase_in);
               if (sess_state == ST_RUN && nph == PH_OFF) begin
                  want_st = 1'b1;
                  nst = ST_DONE;
               end else if (sess_state == ST_DONE && (nph == PH_EXPORT_CHECK ||
                     nph == PH_PRECHARGE || nph == PH_CHARGING)) begin
                  want_st = 1'b1;
                  nst = ST_KEY;
               end
            end
         end
         MODE_ALLOC_RSP: begin
            tick_armed = 1'b0;
            if (sess_state == ST_ALLOC) begin
               fail_flag = !w.alloc_success;
               want_st = 1'b1;
               nst = ST_RUN;
            end
         end
         MODE_KEY: begin
            if (sess_state == ST_KEY) begin
               want_st = 1'b1;
               nst = ST_ALLOC;
            end
         end
         MODE_TICK: begin
            if (tick_armed) begin
               tick_count = tick_count + 16'd1;
               if (tick_count >= cfg_timeout) begin
                  tick_armed = 1'b0;
                  if (sess_state == ST_ALLOC) begin
                     fail_flag = 1'b1;
                     want_st = 1'b1;
                     nst = ST_RUN;
                  end
               end
            end
         end
         MODE_REQUEST: begin
            held_volt = (w.req_voltage_in > VOLT_MAX) ? VOLT_MAX : w.req_voltage_in;
            held_curr = (w.req_current_in > CURR_MAX) ? CURR_MAX : w.req_current_in;
            if (sess_state == ST_RUN) force_frame = 1'b1;
         end
         default: ;
      endcase

      st_chg = want_st && (nst != sess_state);
      ph_chg = want_ph && (nph != sess_phase);
      if (st_chg) sess_state = nst;
      if (ph_chg) sess_phase = nph;

      r = '0;
      if (st_chg) begin
         r.charging_event = (sess_state == ST_RUN) ? EV_START : EV_STOP;
         if (sess_state == ST_ALLOC) begin
            tick_count = '0;
            tick_armed = 1'b1;
         end
         if (sess_state != ST_RUN) fail_flag = 1'b0;
      end

      kind = FR_NONE;
      if (st_chg || ph_chg || force_frame) begin
         case (sess_state)
            ST_ALLOC: kind = FR_ALLOC;
            ST_RUN: begin
               case (sess_phase)
                  PH_OFF:          kind = FR_ALLOC;
                  PH_EXPORT_CHECK: kind = FR_INS_OUT;
                  PH_OFF_CHECK:    kind = FR_INS_STOP;
                  PH_PRECHARGE:    kind = FR_PRECHARGE;
                  default:         kind = FR_CHARGING;
               endcase
            end
            default: kind = FR_STOP;
         endcase
      end
      r.frame_kind = kind;
      if (kind != FR_NONE) r.frame_connector = cfg_connector;
      if (kind == FR_INS_OUT || kind == FR_PRECHARGE || kind == FR_CHARGING) begin
         r.frame_voltage = held_volt;
         r.frame_current = held_curr;
      end

      r.session_state = sess_state;
      r.phase_out = sess_phase;
      case (sess_state)
         ST_DISC:  r.charge_status = WS_STANDBY;
         ST_KEY:   r.charge_status = WS_PLUGGED;
         ST_ALLOC: r.charge_status = WS_STARTING;
         ST_RUN: begin
            r.charge_status = (sess_phase == PH_CHARGING) ? WS_CHARGING : WS_STARTING;
         end
         default:  r.charge_status = WS_COMPLETE;
      endcase
      r.link_status = (sess_state != ST_DISC);
      r.alloc_failed = fail_flag;
      r.status_changed = st_chg || ph_chg;
      return r;
   endfunction

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         fails++;
      end
   endtask

   initial begin
      fails = 0;
      checked = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         sess_state = ST_DISC;
         sess_phase = PH_OFF;
         held_volt = '0;
         held_curr = '0;
         tick_count = '0;
         tick_armed = 1'b0;
         fail_flag = 1'b0;
         cfg_timeout = TIMEOUT_RESET;
         cfg_connector = '0;
         expected_status_q.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_CONNECTOR) cfg_connector = pwdata[7:0];
            else cfg_timeout = pwdata[15:0];
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_status_q.size() == 0) begin
               $error("status word arrived with no event outstanding");
               fails++;
            end else begin
               oldest_status = expected_status_q.pop_front();
               check_field("session_state", oldest_status.session_state,
                           rsp_data.session_state);
               check_field("phase_out", oldest_status.phase_out, rsp_data.phase_out);
               check_field("charge_status", oldest_status.charge_status,
                           rsp_data.charge_status);
               check_field("link_status", oldest_status.link_status,
                           rsp_data.link_status);
               check_field("charging_event", oldest_status.charging_event,
                           rsp_data.charging_event);
               check_field("frame_kind", oldest_status.frame_kind, rsp_data.frame_kind);
               check_field("frame_connector", oldest_status.frame_connector,
                           rsp_data.frame_connector);
               check_field("frame_voltage", oldest_status.frame_voltage,
                           rsp_data.frame_voltage);
               check_field("frame_current", oldest_status.frame_current,
                           rsp_data.frame_current);
               check_field("alloc_failed", oldest_status.alloc_failed,
                           rsp_data.alloc_failed);
               check_field("status_changed", oldest_status.status_changed,
                           rsp_data.status_changed);
               checked++;
            end
         end
         if (req_valid && !req_stall)
            expected_status_q.push_back(predict_session_event(req_data));
      end
      fail_count <= fails;
      pending_count <= expected_status_q.size();
      checked_count <= checked;
   end

endmodule

// File: tb/sv/tb.sv
module tb;
   import ccsf_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int ITEMS_PER_SETTING = 125;
   // phase codes the block has to ignore
   localparam logic [2:0] PH_BAD_LOW = 3'd5;
   localparam logic [2:0] PH_BAD_HIGH = 3'd7;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_data;
   logic         psel = 1'b0;
   logic         penable = 1'b0;
   logic         pwrite = 1'b0;
   logic [2:0]   paddr = '0;
   logic [31:0]  pwdata = '0;
   logic [31:0]  prdata;
   logic         pready;

   int fail_count;
   int pending_count;
   int checked_count;
   int idle_cycles = 0;
   int events_sent = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int tmo_ticks = 100;

   charge_connector_session_fsm dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   session_checker u_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .pready        (pready),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .checked_count (checked_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("FAIL");
      $finish;
   end

   // valid stays high from one word to the next unless an idle gap is drawn
   task automatic send_word(input req_word_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      events_sent++;
   endtask

   function automatic req_word_type make_word(input mode_type m);
      req_word_type w;
      w.mode = m;
      w.phase_in = 3'($urandom_range(7));
      w.alloc_success = 1'($urandom_range(1));
      w.req_voltage_in = 15'($urandom_range(32767));
      w.req_current_in = 14'($urandom_range(16383));
      return w;
   endfunction

   task automatic send_mode(input mode_type m);
      send_word(make_word(m));
   endtask

   task automatic send_phase(input logic [2:0] ph);
      req_word_type w;
      w = make_word(MODE_NEW_PHASE);
      w.phase_in = ph;
      send_word(w);
   endtask

   task automatic send_alloc(input logic ok);
      req_word_type w;
      w = make_word(MODE_ALLOC_RSP);
      w.alloc_success = ok;
      send_word(w);
   endtask

   task automatic send_request(input logic [14:0] volt, input logic [13:0] curr);
      req_word_type w;
      w = make_word(MODE_REQUEST);
      w.req_voltage_in = volt;
      w.req_current_in = curr;
      send_word(w);
   endtask

   task automatic csr_write(input logic reg_sel, input logic [31:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {reg_sel, 2'b00};
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   // wait until every status word is back, then change registers, idling and stalling
   task automatic reconfigure(input int tmo, input int conn, input int idle_set,
                              input int stall_set);
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (3) @(posedge clock);
      csr_write(REG_TIMEOUT, tmo);
      csr_write(REG_CONNECTOR, conn);
      tmo_ticks = tmo;
      send_idle_pct = idle_set;
      stall_pct = stall_set;
   endtask

   // plug in, authorize, wait for allocation, then walk the power phases
   task automatic run_session();
      int        n;
      int        pick;
      phase_type next_ph;
      send_mode(MODE_CONNECT);
      if ($urandom_range(99) < 85) send_mode(MODE_KEY);
      if (tmo_ticks <= 8 && $urandom_range(99) < 60) n = tmo_ticks + $urandom_range(1);
      else n = $urandom_range(3);
      repeat (n) send_mode(MODE_TICK);
      if ($urandom_range(99) < 70) send_alloc(1'($urandom_range(1)));
      next_ph = PH_EXPORT_CHECK;
      n = $urandom_range(3, 12);
      repeat (n) begin
         pick = $urandom_range(99);
         if (pick < 30) begin
            if ($urandom_range(99) < 80)
               send_request(15'($urandom_range(20000)), 14'($urandom_range(10000)));
            else
               send_request(15'($urandom_range(32767)), 14'($urandom_range(16383)));
         end else if (pick < 70) begin
            send_phase(next_ph);
            next_ph = (next_ph == PH_CHARGING) ? PH_OFF : phase_type'(next_ph + 1);
         end else if (pick < 80) begin
            send_phase(3'($urandom_range(7)));
         end else if (pick < 90) begin
            send_mode(MODE_TICK);
         end else if (pick < 95) begin
            send_mode(MODE_KEY);
         end else begin
            send_alloc(1'($urandom_range(1)));
         end
      end
      if ($urandom_range(99) < 80) send_mode(MODE_DISCONNECT);
   endtask

   task automatic run_random();
      int start;
      start = events_sent;
      while (events_sent - start < ITEMS_PER_SETTING) begin
         if ($urandom_range(99) < 20) send_mode(mode_type'($urandom_range(7)));
         else run_session();
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset register values, idle-state events
      send_mode(MODE_TICK);
      send_mode(MODE_NOP);
      send_mode(MODE_DISCONNECT);
      send_alloc(1'b1);
      send_request(15'h7fff, 14'h3fff);
      send_mode(MODE_CONNECT);

      // zero timeout expires on the first armed tick
      reconfigure(0, 255, 0, 0);
      send_mode(MODE_CONNECT);
      send_mode(MODE_KEY);
      send_mode(MODE_TICK);
      send_request(15'd0, 14'd0);
      send_phase(PH_EXPORT_CHECK);
      send_request(VOLT_MAX, CURR_MAX);
      send_phase(PH_BAD_LOW);
      send_phase(PH_BAD_HIGH);
      send_phase(PH_OFF_CHECK);
      send_phase(PH_PRECHARGE);
      send_phase(PH_CHARGING);
      send_phase(PH_CHARGING);
      send_phase(PH_OFF);
      send_phase(PH_OFF_CHECK);
      send_phase(PH_PRECHARGE);
      send_mode(MODE_KEY);
      send_alloc(1'b0);
      send_mode(MODE_DISCONNECT);
      send_mode(MODE_CONNECT);
      send_mode(MODE_KEY);
      send_alloc(1'b1);
      send_mode(MODE_TICK);
      send_mode(MODE_DISCONNECT);

      run_random();
      reconfigure(1, 0, 78, 0);
      run_random();
      reconfigure(5, 8'ha5, 0, 78);
      run_random();
      reconfigure(100, 8'h5a, 31, 31);
      run_random();

      // longest timeout stays armed through a short wait, then allocation arrives
      reconfigure(65535, 1, 0, 0);
      send_mode(MODE_CONNECT);
      send_mode(MODE_KEY);
      repeat (20) send_mode(MODE_TICK);
      send_alloc(1'b1);
      send_request(VOLT_MAX, CURR_MAX);
      send_phase(PH_CHARGING);
      send_mode(MODE_DISCONNECT);

      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (4) @(posedge clock);
      $display("%0d events driven, %0d status words checked", events_sent, checked_count);
      $display("timeouts 0 to 65535 and connector ids 0 to 255 under four idling mixes");
      if (fail_count == 0 && pending_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
